// File: rtl/http_request_header_parser_assert.svh
// Assertion macros used by the HTTP request parser checker
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define HRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// next-cycle implication
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

// File: rtl/hrp_pkg.sv
// Package for the HTTP request header parser: codes, limits and text tables
`default_nettype none
package hrp_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [15:0] MAX_PATH_DEF  = 16'd256;
  localparam logic [7:0]  MAX_NAME_DEF  = 8'd64;
  localparam logic [15:0] MAX_VALUE_DEF = 16'd256;
  localparam logic [7:0]  MAX_HDRS_DEF  = 8'd32;
  localparam logic [23:0] MAX_BODY_DEF  = 24'd1048576;

  localparam logic [2:0] CFG_MAX_PATH  = 3'd0;
  localparam logic [2:0] CFG_MAX_NAME  = 3'd1;
  localparam logic [2:0] CFG_MAX_VALUE = 3'd2;
  localparam logic [2:0] CFG_MAX_HDRS  = 3'd3;
  localparam logic [2:0] CFG_MAX_BODY  = 3'd4;

  localparam logic [1:0] ST_COMPLETE   = 2'd0;
  localparam logic [1:0] ST_REJECTED   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  localparam logic [2:0] METH_UNKNOWN = 3'd6;

  localparam logic [24:0] ACC_OVER = 25'h1000000;
  localparam logic [24:0] ACC_BAD  = 25'h1FFFFFF;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [9:0] {
    PH_METHOD   = 10'b00_0000_0001,
    PH_PATH     = 10'b00_0000_0010,
    PH_QUERY    = 10'b00_0000_0100,
    PH_VERSION  = 10'b00_0000_1000,
    PH_NAME     = 10'b00_0001_0000,
    PH_VALUE    = 10'b00_0010_0000,
    PH_SKIPLINE = 10'b00_0100_0000,
    PH_SKIPREST = 10'b00_1000_0000,
    PH_BODY     = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  localparam logic [2:0] METH_LEN [6] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd4, 3'd7};
  localparam logic [55:0] METH_TEXT [6] = '{
    {"GET", 32'h0}, {"POST", 24'h0}, {"PUT", 32'h0},
    {"DELETE", 8'h0}, {"HEAD", 24'h0}, "OPTIONS"
  };
  localparam logic [4:0] HDR_LEN [3] = '{5'd17, 5'd14, 5'd10};
  localparam logic [135:0] HDR_TEXT [3] = '{
    "transfer-encoding", {"content-length", 24'h0}, {"connection", 56'h0}
  };
  localparam logic [39:0] CLOSE_TEXT = "close";

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] meth_char(input int i, input logic [2:0] p);
    logic [55:0] s;
    s = METH_TEXT[i];
    return (p > 3'd6) ? 8'h00 : s[8*(6-int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] hdr_char(input int i, input logic [4:0] p);
    logic [135:0] s;
    s = HDR_TEXT[i];
    return (p > 5'd16) ? 8'h00 : s[8*(16-int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] p);
    return (p > 3'd4) ? 8'h00 : CLOSE_TEXT[8*(4-int'(p)) +: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/http_request_header_parser.sv
// HTTP/1.1 request header parser: top level
// Takes one request byte per cycle and keeps a running parse of the request
// line and headers; one status transaction comes out when the request ends,
// is rejected, or a byte marked as buffer end leaves it unfinished. Each byte
// passes through one stage of logic from the parse state into the result
// register, so one byte is accepted every cycle; in_ready drops only while a
// result waits in the result register and out_ready is low. A result appears
// on out_valid the cycle after the byte that caused it.
`default_nettype none
module http_request_header_parser #(
  parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        restart,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [2:0]       method,
  output logic [15:0]      path_length,
  output logic [15:0]      query_length,
  output logic [7:0]       headers_seen,
  output logic [23:0]      body_length,
  output logic             keep_connection,
  output logic [15:0]      header_bytes,
  output logic [24:0]      total_bytes
);
  import hrp_pkg::*;

  localparam int LB = LENGTH_BITS;

  typedef struct packed {
    logic [2:0]    cm;
    logic [24:0]   acc;
    logic [LB-1:0] vc;
  } vstate_t;

  logic [15:0] max_path_len, max_value_len;
  logic [7:0]  max_name_len, max_headers;
  logic [23:0] max_body_len;

  phase_t        phase, phase_next;
  logic [23:0]   recent_bytes, recent_bytes_next;
  logic [5:0]    method_match, method_match_next;
  logic [2:0]    method_length, method_length_next;
  logic [LB-1:0] path_count, path_count_next, query_count, query_count_next;
  logic          previous_was_dot, previous_was_dot_next;
  logic [7:0]    header_counter, header_counter_next, name_count, name_count_next;
  logic [2:0]    name_match, name_match_next;
  logic          value_started, value_started_next;
  vstate_t       vst, vst_next;
  logic          length_seen, length_seen_next;
  logic [23:0]   length_value, length_value_next;
  logic          keep_flag, keep_flag_next;
  logic [LB-1:0] byte_counter, byte_counter_next;
  logic [23:0]   body_remaining, body_remaining_next;
  logic          error_flag, error_flag_next;

  logic       fire;
  logic [1:0] fire_code;
  logic [2:0] meth_code;
  logic       accept;

  function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic vstate_t value_step(input vstate_t s, input logic [7:0] c);
    vstate_t r;
    logic [28:0] t;
    r = s;
    t = 29'(s.acc) * 29'd10 + 29'(c - 8'h30);
    if (32'(s.vc) < 32'd5) begin
      if (s.cm == s.vc[2:0] && to_lower(c) == close_char(s.vc[2:0])) r.cm = s.cm + 3'd1;
      else r.cm = 3'd7;
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      if (s.acc <= 25'hFFFFFF) r.acc = (t > 29'hFFFFFF) ? ACC_OVER : t[24:0];
    end else begin
      r.acc = ACC_BAD;
    end
    r.vc = sat_inc(s.vc);
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_path_len  <= MAX_PATH_DEF;
      max_name_len  <= MAX_NAME_DEF;
      max_value_len <= MAX_VALUE_DEF;
      max_headers   <= MAX_HDRS_DEF;
      max_body_len  <= MAX_BODY_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PATH:  max_path_len  <= cfg_data[15:0];
        CFG_MAX_NAME:  max_name_len  <= cfg_data[7:0];
        CFG_MAX_VALUE: max_value_len <= cfg_data[15:0];
        CFG_MAX_HDRS:  max_headers   <= cfg_data[7:0];
        CFG_MAX_BODY:  max_body_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] b, prev;
    b    = data_byte;
    prev = recent_bytes[7:0];
    phase_next            = phase;
    recent_bytes_next     = recent_bytes;
    method_match_next     = method_match;
    method_length_next    = method_length;
    path_count_next       = path_count;
    query_count_next      = query_count;
    previous_was_dot_next = previous_was_dot;
    header_counter_next   = header_counter;
    name_count_next       = name_count;
    name_match_next       = name_match;
    value_started_next    = value_started;
    vst_next              = vst;
    length_seen_next      = length_seen;
    length_value_next     = length_value;
    keep_flag_next        = keep_flag;
    byte_counter_next     = byte_counter;
    body_remaining_next   = body_remaining;
    error_flag_next       = error_flag;
    if (restart) begin
      phase_next            = PH_METHOD;
      recent_bytes_next     = '0;
      method_match_next     = '1;
      method_length_next    = '0;
      path_count_next       = '0;
      query_count_next      = '0;
      previous_was_dot_next = 1'b0;
      header_counter_next   = '0;
      name_count_next       = '0;
      name_match_next       = '1;
      value_started_next    = 1'b0;
      vst_next              = '0;
      length_seen_next      = 1'b0;
      length_value_next     = '0;
      keep_flag_next        = 1'b1;
      byte_counter_next     = '0;
      body_remaining_next   = '0;
      error_flag_next       = 1'b0;
      prev                  = 8'h00;
    end
    fire      = 1'b0;
    fire_code = ST_COMPLETE;

    if (phase_next == PH_BODY) begin
      body_remaining_next = body_remaining_next - 24'd1;
      if (body_remaining_next == '0) begin
        phase_next = PH_DONE;
        fire       = 1'b1;
      end
    end else if (phase_next != PH_DONE) begin
      byte_counter_next = sat_inc(byte_counter_next);
      if (recent_bytes_next == 24'h0D0A0D && b == CH_LF) begin
        if (phase_next == PH_METHOD || phase_next == PH_PATH || phase_next == PH_QUERY)
          error_flag_next = 1'b1;
        if (error_flag_next) begin
          phase_next = PH_DONE;
          fire       = 1'b1;
          fire_code  = ST_REJECTED;
        end else if (length_value_next != '0) begin
          phase_next          = PH_BODY;
          body_remaining_next = length_value_next;
        end else begin
          phase_next = PH_DONE;
          fire       = 1'b1;
        end
      end else begin
        unique case (phase_next)
          PH_METHOD: begin
            if (b == CH_SP) begin
              phase_next = PH_PATH;
            end else begin
              for (int i = 0; i < 6; i++)
                if (method_length_next >= METH_LEN[i] ||
                    meth_char(i, method_length_next) != b)
                  method_match_next[i] = 1'b0;
              if (method_length_next < 3'd7) method_length_next = method_length_next + 3'd1;
            end
          end
          PH_PATH: begin
            if (b == CH_SP || b == CH_QM) begin
              if (32'(path_count_next) >= 32'(max_path_len)) error_flag_next = 1'b1;
              phase_next = (b == CH_SP) ? PH_VERSION : PH_QUERY;
            end else begin
              if (b == CH_DOT && previous_was_dot_next) error_flag_next = 1'b1;
              previous_was_dot_next = (b == CH_DOT);
              path_count_next = sat_inc(path_count_next);
            end
          end
          PH_QUERY: begin
            if (b == CH_SP) begin
              if (32'(query_count_next) >= 32'(max_path_len)) error_flag_next = 1'b1;
              phase_next = PH_VERSION;
            end else begin
              query_count_next = sat_inc(query_count_next);
            end
          end
          PH_VERSION: begin
            if (b == CH_LF) begin
              phase_next = PH_NAME; name_count_next = '0; name_match_next = '1;
            end
          end
          PH_NAME: begin
            if (b == CH_COLON) begin
              if (header_counter_next >= max_headers) begin
                phase_next = PH_SKIPLINE;
              end else begin
                if (name_count_next >= max_name_len) error_flag_next = 1'b1;
                if (name_count_next == 8'd17 && name_match_next[0]) error_flag_next = 1'b1;
                vst_next           = '0;
                value_started_next = 1'b0;
                phase_next         = PH_VALUE;
              end
            end else if (b == CH_LF) begin
              if (name_count_next == 8'd1 && prev == CH_CR) begin
                phase_next = PH_SKIPREST;
              end else begin
                phase_next = PH_NAME; name_count_next = '0; name_match_next = '1;
              end
            end else begin
              for (int i = 0; i < 3; i++)
                if (name_count_next >= 8'(HDR_LEN[i]) ||
                    hdr_char(i, name_count_next[4:0]) != to_lower(b))
                  name_match_next[i] = 1'b0;
              if (name_count_next != 8'hFF) name_count_next = name_count_next + 8'd1;
            end
          end
          PH_VALUE: begin
            if (b == CH_LF) begin
              if (32'(vst_next.vc) >= 32'(max_value_len)) error_flag_next = 1'b1;
              if (name_count_next == 8'd14 && name_match_next[1]) begin
                if (vst_next.vc == '0 || vst_next.acc > {1'b0, max_body_len})
                  error_flag_next = 1'b1;
                else if (length_seen_next && vst_next.acc != {1'b0, length_value_next})
                  error_flag_next = 1'b1;
                else begin
                  length_seen_next  = 1'b1;
                  length_value_next = vst_next.acc[23:0];
                end
              end
              if (name_count_next == 8'd10 && name_match_next[2] && vst_next.cm == 3'd5)
                keep_flag_next = 1'b0;
              if (header_counter_next != 8'hFF) header_counter_next = header_counter_next + 8'd1;
              phase_next = PH_NAME; name_count_next = '0; name_match_next = '1;
            end else if (!value_started_next) begin
              if (b != CH_SP) begin
                value_started_next = 1'b1;
                if (b != CH_CR) vst_next = value_step(vst_next, b);
              end
            end else begin
              if (prev == CH_CR) vst_next = value_step(vst_next, CH_CR);
              if (b != CH_CR) vst_next = value_step(vst_next, b);
            end
          end
          PH_SKIPLINE: begin
            if (b == CH_LF) begin
              phase_next = PH_NAME; name_count_next = '0; name_match_next = '1;
            end
          end
          default: ;
        endcase
        recent_bytes_next = {recent_bytes_next[15:0], b};
      end
    end

    if (!fire && buffer_end && phase_next != PH_DONE) begin
      fire      = 1'b1;
      fire_code = ST_INCOMPLETE;
    end

    meth_code = METH_UNKNOWN;
    for (int i = 5; i >= 0; i--)
      if (method_match_next[i] && method_length_next == METH_LEN[i]) meth_code = 3'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_METHOD;
      recent_bytes     <= '0;
      method_match     <= '1;
      method_length    <= '0;
      path_count       <= '0;
      query_count      <= '0;
      previous_was_dot <= 1'b0;
      header_counter   <= '0;
      name_count       <= '0;
      name_match       <= '1;
      value_started    <= 1'b0;
      vst              <= '0;
      length_seen      <= 1'b0;
      length_value     <= '0;
      keep_flag        <= 1'b1;
      byte_counter     <= '0;
      body_remaining   <= '0;
      error_flag       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        recent_bytes     <= recent_bytes_next;
        method_match     <= method_match_next;
        method_length    <= method_length_next;
        path_count       <= path_count_next;
        query_count      <= query_count_next;
        previous_was_dot <= previous_was_dot_next;
        header_counter   <= header_counter_next;
        name_count       <= name_count_next;
        name_match       <= name_match_next;
        value_started    <= value_started_next;
        vst              <= vst_next;
        length_seen      <= length_seen_next;
        length_value     <= length_value_next;
        keep_flag        <= keep_flag_next;
        byte_counter     <= byte_counter_next;
        body_remaining   <= body_remaining_next;
        error_flag       <= error_flag_next;
      end
      if (accept && fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      status <= fire_code;
      if (fire_code == ST_COMPLETE) begin
        method          <= meth_code;
        path_length     <= 16'(path_count_next);
        query_length    <= 16'(query_count_next);
        headers_seen    <= header_counter_next;
        body_length     <= length_value_next;
        keep_connection <= keep_flag_next;
        header_bytes    <= 16'(byte_counter_next);
        total_bytes     <= 25'(16'(byte_counter_next)) + 25'(length_value_next);
      end else begin
        method          <= '0;
        path_length     <= '0;
        query_length    <= '0;
        headers_seen    <= '0;
        body_length     <= '0;
        keep_connection <= 1'b0;
        header_bytes    <= '0;
        total_bytes     <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hrp_checker.sv
// Port-level checker for the HTTP request header parser, with its bind
`default_nettype none
`include "http_request_header_parser_assert.svh"
module hrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [2:0]  method,
  input wire logic [15:0] path_length,
  input wire logic [23:0] body_length,
  input wire logic [15:0] header_bytes,
  input wire logic [24:0] total_bytes
);
  import hrp_pkg::*;

  `HRP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
  `HRP_ASSERT_NOW(a_stall, out_valid && !out_ready, !in_ready)
  `HRP_ASSERT_NOW(a_zero, out_valid && status != ST_COMPLETE, method == '0 && path_length == '0 && total_bytes == '0)
  `HRP_ASSERT_NOW(a_total, out_valid && status == ST_COMPLETE, total_bytes == {9'd0, header_bytes} + {1'b0, body_length})

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .status(status), .method(method),
  .path_length(path_length), .body_length(body_length),
  .header_bytes(header_bytes), .total_bytes(total_bytes)
);
`default_nettype wire

// File: sim/http_request_header_parser_tb.sv
// Testbench for http_request_header_parser: byte-stream requests checked against a behavioral predictor
module http_request_header_parser_tb;
  import hrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_SAT = 65535;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  method;
    logic [15:0] path_length;
    logic [15:0] query_length;
    logic [7:0]  headers_seen;
    logic [23:0] body_length;
    logic        keep_connection;
    logic [15:0] header_bytes;
    logic [24:0] total_bytes;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_MAX_PATH;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        restart = 1'b0;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [2:0]  method;
  logic [15:0] path_length, query_length, header_bytes;
  logic [7:0]  headers_seen;
  logic [23:0] body_length;
  logic        keep_connection;
  logic [24:0] total_bytes;

  http_request_header_parser DUT (.*);

  always #5 clk = ~clk;

  // limits mirrored from the register writes
  int unsigned lim_path = 32'(MAX_PATH_DEF), lim_name = 32'(MAX_NAME_DEF);
  int unsigned lim_value = 32'(MAX_VALUE_DEF);
  int unsigned lim_hdrs = 32'(MAX_HDRS_DEF), lim_body = 32'(MAX_BODY_DEF);

  // parse state of the predictor
  phase_t      ph;
  logic [23:0] tail;
  logic [5:0]  meth_live;
  int unsigned meth_len, path_n, query_n, hdr_n, name_n, value_n, close_n, acc;
  logic [2:0]  name_live;
  bit          last_dot, value_on, cl_seen, keep, bad;
  int unsigned len_value, byte_n, body_left;

  string meth_names[6] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS"};
  string hdr_names[3] = '{"transfer-encoding", "content-length", "connection"};
  string close_word = "close";

  outcome_t    pending_outcomes[$];
  logic [7:0]  req_bytes[$];
  int          errors = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;
  int          rx_mode = 0;
  int          rx_count = 0;

  function automatic int unsigned sat16(input int unsigned v);
    return (v < LEN_SAT) ? v + 1 : v;
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_parse();
    ph = PH_METHOD; tail = '0; meth_live = '1; meth_len = 0;
    path_n = 0; query_n = 0; last_dot = 0; hdr_n = 0;
    name_n = 0; name_live = '1; value_n = 0; value_on = 0; close_n = 0;
    acc = 0; cl_seen = 0; len_value = 0; keep = 1; byte_n = 0; body_left = 0; bad = 0;
  endfunction

  function automatic void new_line();
    ph = PH_NAME; name_n = 0; name_live = '1;
  endfunction

  function automatic void value_char(input logic [7:0] c);
    if (value_n < 5) begin
      if (close_n == value_n && lower_case(c) == close_word[value_n]) close_n++;
      else close_n = 7;
    end
    if (c >= "0" && c <= "9") begin
      if (acc <= 32'hFFFFFF) begin
        acc = acc * 10 + 32'(c - "0");
        if (acc > 32'hFFFFFF) acc = 32'(ACC_OVER);
      end
    end else begin
      acc = 32'(ACC_BAD);
    end
    value_n = sat16(value_n);
  endfunction

  function automatic void close_header();
    if (value_n >= lim_value) bad = 1;
    if (name_n == 14 && name_live[1]) begin
      if (value_n == 0 || acc > lim_body) bad = 1;
      else if (cl_seen && acc != len_value) bad = 1;
      else begin
        cl_seen = 1; len_value = acc;
      end
    end
    if (name_n == 10 && name_live[2] && close_n == 5) keep = 0;
    if (hdr_n < 255) hdr_n++;
  endfunction

  function automatic void header_char(input logic [7:0] b);
    logic [7:0] prev;
    prev = tail[7:0];
    case (ph)
      PH_METHOD: begin
        if (b == CH_SP) ph = PH_PATH;
        else begin
          for (int i = 0; i < 6; i++)
            if (meth_len >= meth_names[i].len() || meth_names[i][meth_len] != b)
              meth_live[i] = 0;
          if (meth_len < 7) meth_len++;
        end
      end
      PH_PATH: begin
        if (b == CH_SP || b == CH_QM) begin
          if (path_n >= lim_path) bad = 1;
          ph = (b == CH_SP) ? PH_VERSION : PH_QUERY;
        end else begin
          if (b == CH_DOT && last_dot) bad = 1;
          last_dot = (b == CH_DOT);
          path_n = sat16(path_n);
        end
      end
      PH_QUERY: begin
        if (b == CH_SP) begin
          if (query_n >= lim_path) bad = 1;
          ph = PH_VERSION;
        end else query_n = sat16(query_n);
      end
      PH_VERSION: if (b == CH_LF) new_line();
      PH_NAME: begin
        if (b == CH_COLON) begin
          if (hdr_n >= lim_hdrs) ph = PH_SKIPLINE;
          else begin
            if (name_n >= lim_name) bad = 1;
            if (name_n == 17 && name_live[0]) bad = 1;
            value_n = 0; value_on = 0; close_n = 0; acc = 0; ph = PH_VALUE;
          end
        end else if (b == CH_LF) begin
          if (name_n == 1 && prev == CH_CR) ph = PH_SKIPREST;
          else new_line();
        end else begin
          for (int i = 0; i < 3; i++)
            if (name_n >= hdr_names[i].len() || hdr_names[i][name_n] != lower_case(b))
              name_live[i] = 0;
          if (name_n < 255) name_n++;
        end
      end
      PH_VALUE: begin
        if (b == CH_LF) begin
          close_header(); new_line();
        end else if (!value_on) begin
          if (b != CH_SP) begin
            value_on = 1;
            if (b != CH_CR) value_char(b);
          end
        end else begin
          if (prev == CH_CR) value_char(CH_CR);
          if (b != CH_CR) value_char(b);
        end
      end
      PH_SKIPLINE: if (b == CH_LF) new_line();
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] method_code();
    for (int i = 0; i < 6; i++)
      if (meth_live[i] && meth_len == meth_names[i].len()) return 3'(i);
    return METH_UNKNOWN;
  endfunction

  // advances the parse by one byte; returns 1 when an outcome is due
  function automatic bit parse_byte(input logic [7:0] b, input bit rs, input bit be,
                                    output outcome_t r);
    int st;
    st = -1;
    r = '0;
    if (rs) clear_parse();
    if (ph == PH_BODY) begin
      body_left--;
      if (body_left == 0) begin
        ph = PH_DONE; st = ST_COMPLETE;
      end
    end else if (ph != PH_DONE) begin
      byte_n = sat16(byte_n);
      if (tail == 24'h0D0A0D && b == CH_LF) begin
        if (ph == PH_METHOD || ph == PH_PATH || ph == PH_QUERY) bad = 1;
        if (bad) begin
          ph = PH_DONE; st = ST_REJECTED;
        end else if (len_value > 0) begin
          ph = PH_BODY; body_left = len_value;
        end else begin
          ph = PH_DONE; st = ST_COMPLETE;
        end
      end else begin
        header_char(b);
        tail = {tail[15:0], b};
      end
    end
    if (st < 0 && be && ph != PH_DONE) st = ST_INCOMPLETE;
    if (st < 0) return 0;
    r.status = st[1:0];
    if (st == ST_COMPLETE) begin
      r.method = method_code();
      r.path_length = path_n[15:0];
      r.query_length = query_n[15:0];
      r.headers_seen = hdr_n[7:0];
      r.body_length = len_value[23:0];
      r.keep_connection = keep;
      r.header_bytes = byte_n[15:0];
      r.total_bytes = 25'(byte_n[15:0]) + 25'(len_value[23:0]);
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t got, want;
    got = {status, method, path_length, query_length, headers_seen, body_length,
           keep_connection, header_bytes, total_bytes};
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("[%0t] unexpected result transaction, status %0d", $time, status);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.method !== want.method) report_mismatch("method", got.method, want.method);
        if (got.path_length !== want.path_length)
          report_mismatch("path_length", got.path_length, want.path_length);
        if (got.query_length !== want.query_length)
          report_mismatch("query_length", got.query_length, want.query_length);
        if (got.headers_seen !== want.headers_seen)
          report_mismatch("headers_seen", got.headers_seen, want.headers_seen);
        if (got.body_length !== want.body_length)
          report_mismatch("body_length", got.body_length, want.body_length);
        if (got.keep_connection !== want.keep_connection)
          report_mismatch("keep_connection", got.keep_connection, want.keep_connection);
        if (got.header_bytes !== want.header_bytes)
          report_mismatch("header_bytes", got.header_bytes, want.header_bytes);
        if (got.total_bytes !== want.total_bytes)
          report_mismatch("total_bytes", got.total_bytes, want.total_bytes);
      end
    end
  end

  // receiver: stall mode is redrawn at random; long hold-off on request
  always @(negedge clk) begin
    rx_count++;
    if (rx_count % 64 == 0) rx_mode = int'($urandom_range(0, 2));
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** http_request_header_parser: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit rs, input bit be);
    outcome_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : int'($urandom_range(1, 24));
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    restart <= rs;
    buffer_end <= be;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (parse_byte(b, rs, be, r)) pending_outcomes.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_request();
    int n;
    n = req_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(req_bytes[i], i == 0, i == n - 1 || $urandom_range(0, 29) == 0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_PATH:  lim_path = val & 16'hFFFF;
      CFG_MAX_NAME:  lim_name = val & 8'hFF;
      CFG_MAX_VALUE: lim_value = val & 16'hFFFF;
      CFG_MAX_HDRS:  lim_hdrs = val & 8'hFF;
      default:       lim_body = val & 24'hFFFFFF;
    endcase
  endtask

  task automatic write_all(input int unsigned p, input int unsigned n, input int unsigned v,
                           input int unsigned h, input int unsigned bmax);
    wait_idle();
    write_limit(CFG_MAX_PATH, p);
    write_limit(CFG_MAX_NAME, n);
    write_limit(CFG_MAX_VALUE, v);
    write_limit(CFG_MAX_HDRS, h);
    write_limit(CFG_MAX_BODY, bmax);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void push_line(input string s);
    push_text(s);
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endfunction

  task automatic send_text_request(input string head, input string body, input bit finish);
    req_bytes.delete();
    push_text(head);
    if (finish) push_line("");
    push_text(body);
    send_request();
  endtask

  function automatic logic [7:0] path_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) return CH_DOT;
    do c = 8'($urandom_range(33, 126)); while (c == CH_QM);
    return c;
  endfunction

  function automatic void build_random_request();
    int nh, body_n;
    string num;
    req_bytes.delete();
    body_n = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(4, 40)) req_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 4) != 0) push_text(meth_names[$urandom_range(0, 5)]);
    else repeat ($urandom_range(1, 9)) req_bytes.push_back(8'($urandom_range(65, 90)));
    req_bytes.push_back(CH_SP);
    req_bytes.push_back("/");
    repeat (($urandom_range(0, 40) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 12))
      req_bytes.push_back(path_char());
    if ($urandom_range(0, 2) == 0) begin
      req_bytes.push_back(CH_QM);
      repeat ($urandom_range(0, 10)) req_bytes.push_back(8'($urandom_range(33, 126)));
    end
    push_text(" HTTP/1.1");
    if ($urandom_range(0, 15) == 0) req_bytes.push_back(CH_LF);
    else push_line("");
    nh = int'($urandom_range(0, 6));
    for (int k = 0; k < nh; k++) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          body_n = int'($urandom_range(0, 12));
          num.itoa(body_n);
          push_line({($urandom_range(0, 1) ? "Content-Length:" : "content-LENGTH:"),
                     ($urandom_range(0, 1) ? "  " : ""), num});
        end
        3: push_line({"Content-Length: ", ($urandom_range(0, 1) ? "1x" : "99999999")});
        4: push_line("Content-Length:");
        5: push_line({"Connection: ", ($urandom_range(0, 1) ? "close" : "CLOSE")});
        6: push_line({"Connection: ", ($urandom_range(0, 1) ? "keep-alive" : "clos")});
        7: push_line("Transfer-Encoding: chunked");
        8: push_line("no colon here");
        9: begin
          push_text("X-Plain: v");
          req_bytes.push_back(CH_LF);
        end
        default: begin
          repeat ($urandom_range(1, 20)) req_bytes.push_back(8'($urandom_range(97, 122)));
          req_bytes.push_back(CH_COLON);
          repeat ($urandom_range(0, 20)) req_bytes.push_back(8'($urandom_range(32, 126)));
          push_line("");
        end
      endcase
    end
    push_line("");
    repeat (body_n) req_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0 && req_bytes.size() > 2)
      req_bytes = req_bytes[0:$urandom_range(1, req_bytes.size() - 2)];
  endfunction

  task automatic run_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_request();
      send_request();
    end
  endtask

  task automatic test_directed();
    send_text_request({"GET /index.html?a=1 HTTP/1.1\015\012Host: x\015\012"}, "", 1);
    send_text_request({"POST /up HTTP/1.1\015\012Content-Length: 3\015\012"}, "abc", 1);
    send_text_request({"PUT /a/../b HTTP/1.1\015\012"}, "", 1);
    send_text_request({"DELETE / HTTP/1.1\015\012Transfer-Encoding: chunked\015\012"}, "", 1);
    send_text_request({"HEAD / HTTP/1.1\015\012Connection: Close\015\012"}, "", 1);
    send_text_request({"OPTIONS * HTTP/1.1\015\012Content-Length: 2\015\012",
                       "Content-Length: 3\015\012"}, "", 1);
    send_text_request({"GETX / HTTP/1.1\015\012nocolon\015\012A:  b\015\012"}, "", 1);
    send_text_request({"GET\015\012"}, "", 1);
    send_text_request({"GET / HTTP/1.1\012\015\012X: y\015\012"}, "", 1);
    send_text_request({"GET / HTTP/1.1\015\012Host"}, "", 0);
    req_bytes.delete();
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(8'h00);
    send_request();
  endtask

  task automatic test_limits();
    write_all(1, 1, 1, 0, 0);
    run_random(100);
    write_all(65535, 255, 65535, 255, 24'hFFFFFF);
    run_random(100);
    write_all(8, 12, 6, 2, 5);
    run_random(100);
    write_all(32'(MAX_PATH_DEF), 32'(MAX_NAME_DEF), 32'(MAX_VALUE_DEF), 32'(MAX_HDRS_DEF),
              32'(MAX_BODY_DEF));
  endtask

  task automatic test_random_stream();
    run_random(300);
  endtask

  task automatic test_output_stall();
    wait_idle();
    hold_cycles = 400;
    run_random(200);
  endtask

  initial begin
    clear_parse();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    test_random_stream();
    test_output_stall();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("** http_request_header_parser: PASSED **");
    else $display("** http_request_header_parser: FAILED **");
    $finish;
  end
endmodule
